// ===== hdl/cpm_pkg.sv =====
// Package for the clock period meter: beat types, register indexes,
// sequencer states and fixed widths. No dependencies.
package cpm_pkg;

   localparam int HZ_W          = 28;
   localparam int STALE_W       = 16;
   localparam int PPQ_W         = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 28;
   localparam int TIME_W        = 32;
   localparam int FREQ_W        = 44;
   localparam int BPM_W         = 50;
   localparam int BPM_MUL_W     = 6;
   localparam int FRACTION_BITS_DEF = 16;

   localparam logic [HZ_W-1:0]    HZ_RESET    = 28'd84000000;
   localparam logic [STALE_W-1:0] STALE_RESET = 16'd1500;
   localparam logic [PPQ_W-1:0]   PPQ_RESET   = 8'd24;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_HZ    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PPQ         = 2'd2;

   typedef struct packed {
      logic              capture_valid;
      logic [TIME_W-1:0] capture_value;
      logic [TIME_W-1:0] now_ms;
      logic              take_edge;
   } req_type;

   typedef struct packed {
      logic              clock_present;
      logic [TIME_W-1:0] period_count;
      logic              edge_seen;
      logic [FREQ_W-1:0] freq_hz_q16;
      logic [BPM_W-1:0]  bpm_q16;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_FREQ,
      ST_DIV_BPM,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/clock_period_meter_with_timeout.sv =====
// Clock period meter with staleness timeout: capture bookkeeping, one shared
// restoring divider for frequency and BPM. Depends on cpm_pkg.
// Sequence: accept, prepare, frequency division, BPM division, result register; both
// divisions are skipped when no clock is held, and the BPM division is skipped
// when pulses per quarter is zero. One beat at a time: the next is taken once the
// result registers; a stalled result holds it. Sync reset.
module clock_period_meter_with_timeout #(
   parameter int FRACTION_BITS = cpm_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cpm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cpm_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [cpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cpm_pkg::*;

   localparam int FQ_W  = HZ_W + FRACTION_BITS;
   localparam int NUM_W = HZ_W + BPM_MUL_W + FRACTION_BITS;
   localparam int DSR_W = TIME_W + PPQ_W;
   localparam int CNT_W = $clog2(NUM_W);

   logic [HZ_W-1:0]    hz_ff;
   logic [STALE_W-1:0] stale_ff;
   logic [PPQ_W-1:0]   ppq_ff;

   logic [TIME_W-1:0]  prev_capture_ff, prev_capture_in;
   logic               prev_seen_ff, prev_seen_in;
   logic [TIME_W-1:0]  period_ff, period_in;
   logic [TIME_W-1:0]  last_edge_ff, last_edge_in;
   logic               pending_ff, pending_in;
   logic               edge_seen_ff, edge_seen_in;

   state_type          state_ff, state_in;
   logic [NUM_W-1:0]   dvd_ff, dvd_in;
   logic [DSR_W-1:0]   dsr_ff, dsr_in;
   logic [DSR_W-1:0]   rem_ff, rem_in;
   logic [DSR_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [BPM_W-1:0]   bpm_ff, bpm_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [TIME_W-1:0]  diff;
   logic [TIME_W-1:0]  age;
   logic [DSR_W:0]     trial;
   logic [DSR_W:0]     trial_sub;
   logic               trial_ge;
   logic [NUM_W-1:0]   dvd_step;
   logic [DSR_W-1:0]   rem_step;
   logic [HZ_W+BPM_MUL_W-1:0] hz60;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared divider step: one restoring quotient bit per cycle
   assign trial     = {rem_ff, dvd_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign trial_ge  = !trial_sub[DSR_W];
   assign rem_step  = trial_ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
   assign dvd_step  = {dvd_ff[NUM_W-2:0], trial_ge};

   assign hz60 = {hz_ff, 6'd0} - {4'd0, hz_ff, 2'd0};
   assign diff = req_data.capture_value - prev_capture_ff;
   assign age  = req_data.now_ms - last_edge_ff;

   always_comb begin
      prev_capture_in = prev_capture_ff;
      prev_seen_in    = prev_seen_ff;
      period_in       = period_ff;
      last_edge_in    = last_edge_ff;
      pending_in      = pending_ff;
      edge_seen_in    = edge_seen_ff;
      state_in        = state_ff;
      dvd_in          = dvd_ff;
      dsr_in          = dsr_ff;
      rem_in          = rem_ff;
      prod_in         = prod_ff;
      cnt_in          = cnt_ff;
      freq_in         = freq_ff;
      bpm_in          = bpm_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.capture_valid) begin
                  if (prev_seen_ff && (diff != '0)) begin
                     period_in = diff;
                  end
                  prev_capture_in = req_data.capture_value;
                  prev_seen_in    = 1'b1;
                  last_edge_in    = req_data.now_ms;
                  edge_seen_in    = 1'b1;
               end else begin
                  edge_seen_in = pending_ff;
                  if ((period_ff != '0) && (age > {{(TIME_W-STALE_W){1'b0}}, stale_ff})) begin
                     period_in    = '0;
                     prev_seen_in = 1'b0;
                  end
               end
               pending_in = edge_seen_in && !req_data.take_edge;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            freq_in = '0;
            bpm_in  = '0;
            prod_in = DSR_W'(period_ff * ppq_ff);
            dsr_in  = DSR_W'(period_ff);
            rem_in  = '0;
            dvd_in  = NUM_W'(hz_ff) << (NUM_W - HZ_W);
            cnt_in  = CNT_W'(FQ_W - 1);
            state_in = (period_ff != '0) ? ST_DIV_FREQ : ST_DONE;
         end
         ST_DIV_FREQ: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               freq_in = FREQ_W'(dvd_step);
               if (ppq_ff != '0) begin
                  dsr_in   = prod_ff;
                  rem_in   = '0;
                  dvd_in   = NUM_W'(hz60) << FRACTION_BITS;
                  cnt_in   = CNT_W'(NUM_W - 1);
                  state_in = ST_DIV_BPM;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV_BPM: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               bpm_in   = BPM_W'(dvd_step);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.clock_present = (period_ff != '0);
               rsp_data_in.period_count  = period_ff;
               rsp_data_in.edge_seen     = edge_seen_ff;
               rsp_data_in.freq_hz_q16   = freq_ff;
               rsp_data_in.bpm_q16       = bpm_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff    <= HZ_RESET;
         stale_ff <= STALE_RESET;
         ppq_ff   <= PPQ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMER_HZ:    hz_ff    <= csr_wdata[HZ_W-1:0];
            CSR_STALE_LIMIT: stale_ff <= csr_wdata[STALE_W-1:0];
            CSR_PPQ:         ppq_ff   <= csr_wdata[PPQ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         prev_capture_ff <= '0;
         prev_seen_ff    <= 1'b0;
         period_ff       <= '0;
         last_edge_ff    <= '0;
         pending_ff      <= 1'b0;
         edge_seen_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         prev_capture_ff <= prev_capture_in;
         prev_seen_ff    <= prev_seen_in;
         period_ff       <= period_in;
         last_edge_ff    <= last_edge_in;
         pending_ff      <= pending_in;
         edge_seen_ff    <= edge_seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      rem_ff      <= rem_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      freq_ff     <= freq_in;
      bpm_ff      <= bpm_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the clock period meter: directed and random polls with a scoreboard
// that predicts period, pending flag, frequency and BPM for every accepted beat.
// Depends on cpm_pkg and clock_period_meter_with_timeout.
module tb_top;
   import cpm_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 110;
   localparam int SEG_POLLS     = 232;
   localparam int MAX_PRINTS    = 20;
   localparam int DRAIN_LIMIT   = 20000;

   class meter_scoreboard;
      logic [HZ_W-1:0]    hz;
      logic [STALE_W-1:0] stale_limit;
      logic [PPQ_W-1:0]   ppq;
      logic [TIME_W-1:0]  prev_capture;
      logic [TIME_W-1:0]  period;
      logic [TIME_W-1:0]  last_edge;
      bit                 prev_seen;
      bit                 pending;
      rsp_type            expected_q[$];
      int                 mismatches;
      int                 results_seen;
      int                 polls_seen;
      int                 stale_drops;
      int                 zero_diffs;

      function new();
         hz = HZ_RESET;
         stale_limit = STALE_RESET;
         ppq = PPQ_RESET;
         prev_capture = '0;
         period = '0;
         last_edge = '0;
         prev_seen = 1'b0;
         pending = 1'b0;
         mismatches = 0;
         results_seen = 0;
         polls_seen = 0;
         stale_drops = 0;
         zero_diffs = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_TIMER_HZ:    hz = value[HZ_W-1:0];
            CSR_STALE_LIMIT: stale_limit = value[STALE_W-1:0];
            CSR_PPQ:         ppq = value[PPQ_W-1:0];
            default:         ;
         endcase
      endfunction

      function void note_poll(req_type beat);
         rsp_type           exp;
         logic [TIME_W-1:0] diff;
         logic [TIME_W-1:0] age;
         logic [63:0]       num;
         logic [63:0]       den;
         exp = '0;
         polls_seen++;
         if (beat.capture_valid) begin
            if (prev_seen) begin
               diff = beat.capture_value - prev_capture;
               if (diff != '0)
                  period = diff;
               else
                  zero_diffs++;
            end
            prev_capture = beat.capture_value;
            prev_seen = 1'b1;
            last_edge = beat.now_ms;
            pending = 1'b1;
         end else begin
            age = beat.now_ms - last_edge;
            if (period != '0 && age > TIME_W'(stale_limit)) begin
               period = '0;
               prev_seen = 1'b0;
               stale_drops++;
            end
         end
         exp.clock_present = (period != '0);
         exp.period_count = period;
         exp.edge_seen = pending;
         if (period != '0) begin
            num = 64'(hz) << FRACTION_BITS_DEF;
            exp.freq_hz_q16 = FREQ_W'(num / 64'(period));
            if (ppq != '0) begin
               num = (64'(hz) * 64'd60) << FRACTION_BITS_DEF;
               den = 64'(period) * 64'(ppq);
               exp.bpm_q16 = BPM_W'(num / den);
            end
         end
         expected_q.push_back(exp);
         if (beat.take_edge)
            pending = 1'b0;
      endfunction

      task report_mismatch(string what, logic [63:0] got_v, logic [63:0] exp_v);
         if (mismatches < MAX_PRINTS)
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got_v, exp_v);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type exp;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no poll pending", 64'(got.period_count), 64'd0);
         end else begin
            exp = expected_q.pop_front();
            if (got.clock_present !== exp.clock_present)
               report_mismatch("clock_present", 64'(got.clock_present), 64'(exp.clock_present));
            if (got.period_count !== exp.period_count)
               report_mismatch("period_count", 64'(got.period_count), 64'(exp.period_count));
            if (got.edge_seen !== exp.edge_seen)
               report_mismatch("edge_seen", 64'(got.edge_seen), 64'(exp.edge_seen));
            if (got.freq_hz_q16 !== exp.freq_hz_q16)
               report_mismatch("freq_hz_q16", 64'(got.freq_hz_q16), 64'(exp.freq_hz_q16));
            if (got.bpm_q16 !== exp.bpm_q16)
               report_mismatch("bpm_q16", 64'(got.bpm_q16), 64'(exp.bpm_q16));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TIMER_HZ;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   bit                 hold_go = 1'b0;
   int                 hold_count = 0;
   logic [TIME_W-1:0]  cap_cursor = '0;
   logic [TIME_W-1:0]  ms_cursor = '0;
   logic [TIME_W-1:0]  edge_ms = '0;
   logic [TIME_W-1:0]  nominal = 32'd84000;
   logic [STALE_W-1:0] cur_stale = STALE_RESET;
   meter_scoreboard    sb = new();

   clock_period_meter_with_timeout dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result side at random, and once hold it off for a long stretch
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_poll(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
      end
   end

   function automatic req_type build_poll(logic cv, logic [TIME_W-1:0] cap,
                                          logic [TIME_W-1:0] now, logic take);
      req_type beat;
      beat.capture_valid = cv;
      beat.capture_value = cap;
      beat.now_ms = now;
      beat.take_edge = take;
      return beat;
   endfunction

   function automatic req_type next_random_poll();
      req_type beat;
      int      pick;
      beat = '0;
      pick = $urandom_range(99);
      beat.take_edge = 1'($urandom_range(1));
      if (pick < 55) begin
         cap_cursor = cap_cursor + nominal + 32'($urandom_range(6)) - 32'd3;
         ms_cursor = ms_cursor + 32'($urandom_range(40));
         edge_ms = ms_cursor;
         beat.capture_valid = 1'b1;
         beat.capture_value = cap_cursor;
      end else if (pick < 60) begin
         ms_cursor = ms_cursor + 32'($urandom_range(5));
         edge_ms = ms_cursor;
         beat.capture_valid = 1'b1;
         beat.capture_value = cap_cursor;
      end else if (pick < 72) begin
         ms_cursor = ms_cursor + 32'($urandom_range(200));
      end else if (pick < 84) begin
         // land just around the stale limit
         ms_cursor = edge_ms + 32'(cur_stale) + 32'($urandom_range(3)) - 32'd1;
      end else if (pick < 87) begin
         ms_cursor = ms_cursor + $urandom;
      end else if (pick < 95) begin
         case ($urandom_range(2))
            0:       nominal = $urandom_range(1000, 1);
            1:       nominal = $urandom_range(2000000, 1000);
            default: nominal = $urandom;
         endcase
         cap_cursor = cap_cursor + nominal;
         ms_cursor = ms_cursor + 32'($urandom_range(40));
         edge_ms = ms_cursor;
         beat.capture_valid = 1'b1;
         beat.capture_value = cap_cursor;
      end
      if (pick < 95) begin
         beat.now_ms = ms_cursor;
      end else begin
         beat.capture_valid = 1'($urandom_range(1));
         beat.capture_value = $urandom;
         beat.now_ms = $urandom;
      end
      return beat;
   endfunction

   task automatic send_poll(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [HZ_W-1:0] hz, logic [STALE_W-1:0] stale,
                             logic [PPQ_W-1:0] ppq);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_TIMER_HZ;
      csr_wdata <= CSR_DATA_W'(hz);
      @(posedge clock);
      csr_index <= CSR_STALE_LIMIT;
      csr_wdata <= CSR_DATA_W'(stale);
      @(posedge clock);
      csr_index <= CSR_PPQ;
      csr_wdata <= CSR_DATA_W'(ppq);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(CSR_TIMER_HZ, CSR_DATA_W'(hz));
      sb.set_reg(CSR_STALE_LIMIT, CSR_DATA_W'(stale));
      sb.set_reg(CSR_PPQ, CSR_DATA_W'(ppq));
      cur_stale = stale;
   endtask

   initial begin
      int seg;
      int i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 17;
      recv_idle_pct = 88;
      send_poll(build_poll(1'b0, '0, 32'd0, 1'b1));
      send_poll(build_poll(1'b1, 32'd1000, 32'd10, 1'b0));
      send_poll(build_poll(1'b1, 32'd85000, 32'd20, 1'b1));
      send_poll(build_poll(1'b1, 32'd85000, 32'd30, 1'b0));
      send_poll(build_poll(1'b0, '0, 32'd1530, 1'b1));
      send_poll(build_poll(1'b0, '0, 32'd1531, 1'b0));
      send_poll(build_poll(1'b0, '1, '1, 1'b1));
      send_poll(build_poll(1'b1, 32'hFFFF_FF00, 32'hFFFF_FFF0, 1'b0));
      send_poll(build_poll(1'b1, 32'h0000_0100, 32'hFFFF_FFF8, 1'b1));
      send_poll(build_poll(1'b0, '1, 32'h0000_05D4, 1'b0));
      send_poll(build_poll(1'b0, '0, 32'h0000_05D5, 1'b1));
      send_poll(build_poll(1'b1, '1, 32'd100, 1'b0));
      send_poll(build_poll(1'b1, 32'hFFFF_FFFE, 32'd101, 1'b0));
      send_poll(build_poll(1'b1, '1, 32'd102, 1'b1));
      send_poll(build_poll(1'b1, '0, 32'd103, 1'b0));
      send_poll(build_poll(1'b0, '0, 32'd103, 1'b1));
      send_poll(build_poll(1'b0, '0, 32'd103, 1'b0));
      ms_cursor = 32'd103;
      edge_ms = 32'd103;

      for (seg = 0; seg < 6; seg++) begin
         case (seg)
            1: set_config(28'hFFF_FFFF, 16'd0, 8'd0);
            2: set_config(28'd1, 16'hFFFF, 8'hFF);
            3: set_config(28'd0, 16'($urandom_range(3000, 1)), 8'd1);
            4: set_config(28'($urandom_range(28'hFFF_FFFF, 1)), 16'($urandom_range(200)),
                          8'($urandom_range(255)));
            5: set_config(28'($urandom_range(28'hFFF_FFFF, 1)), 16'($urandom),
                          8'($urandom_range(255, 1)));
            default: ;
         endcase
         if (seg < 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 88;
         end else if (seg < 4) begin
            send_idle_pct = 88;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (seg == 4)
            hold_go <= 1'b1;
         for (i = 0; i < SEG_POLLS; i++)
            send_poll(next_random_poll());
      end

      drain();
      if (sb.expected_q.size() != 0)
         sb.report_mismatch("polls left without a result", 64'(sb.expected_q.size()), 64'd0);
      $display("Ran %0d polls through six register settings, %0d results checked.",
               sb.polls_seen, sb.results_seen);
      $display("Covered %0d stale drops and %0d zero-difference captures, %0d mismatches.",
               sb.stale_drops, sb.zero_diffs, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #15000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
